// ===== sv/humidity_temp_frame_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the humidity/temperature frame decoder
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check gated off while reset is high
`define HTFD_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
// check that also covers the reset cycles
`define HTFD_ASSERT(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");
`else
`define HTFD_ASSERT_RST(lbl, clk, rst, prop)
`define HTFD_ASSERT(lbl, clk, prop)
`endif

`endif

// ===== sv/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// Types, constants and the CRC-8 step shared by the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

   localparam int unsigned DATA_BYTES = 6;   // status + five data bytes
   localparam int unsigned POS_W      = 3;   // byte position 0..6
   localparam int unsigned RAW_W      = 20;
   localparam int unsigned TEMP_W     = 15;
   localparam int unsigned HUM_W      = 14;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // raw codes are fractions of 2^20
   localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;  // 200.00 C span
   localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;   // -50.00 C
   localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;  // 100.00 %

   typedef struct packed {
      logic [7:0]       status_byte;
      logic [RAW_W-1:0] humidity_code;
      logic [RAW_W-1:0] temperature_code;
      logic             crc_ok;
   } frame_type;

   // one byte through CRC-8, MSB first, no final xor
   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== sv/htfd_if.sv =====
// ----------------------------------------------------------------------------
// htfd_req_if / htfd_rsp_if
// Valid/ready channels for received bytes and decoded measurements.
// ----------------------------------------------------------------------------
`default_nettype none

interface htfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [7:0]                             status_byte;
   logic [htfd_pkg::RAW_W-1:0]             humidity_code;
   logic [htfd_pkg::RAW_W-1:0]             temperature_code;
   logic                                   crc_ok;
   logic                                   humidity_valid;
   logic signed [htfd_pkg::TEMP_W-1:0]     temperature_centi;
   logic [htfd_pkg::HUM_W-1:0]             humidity_centi;

   modport source (output valid, output status_byte, output humidity_code,
                   output temperature_code, output crc_ok, output humidity_valid,
                   output temperature_centi, output humidity_centi, input ready);
   modport sink   (input valid, input status_byte, input humidity_code,
                   input temperature_code, input crc_ok, input humidity_valid,
                   input temperature_centi, input humidity_centi, output ready);
endinterface

`default_nettype wire

// ===== sv/htfd_collect.sv =====
// ----------------------------------------------------------------------------
// htfd_collect
// Frame tracking, byte store and running CRC; hands out one frame record.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_temp_frame_decoder_top_defines.svh"

module htfd_collect (
   input  wire logic          clock,
   input  wire logic          reset,
   htfd_req_if.sink           req_ch,
   output logic               frm_valid,
   input  wire logic          frm_ready,
   output htfd_pkg::frame_type frm
);

   logic [htfd_pkg::POS_W-1:0] byte_position_ff, byte_position_in;
   logic [7:0]                 crc_ff, crc_in;
   logic                       frame_done_ff, frame_done_in;
   logic                       frm_valid_ff, frm_valid_in;
   htfd_pkg::frame_type        frm_ff, frm_in;
   logic [7:0]                 store_ff [htfd_pkg::DATA_BYTES];

   logic                       req_ready;
   logic                       req_fire;
   logic [htfd_pkg::POS_W-1:0] pos_eff;
   logic [7:0]                 crc_eff;
   logic                       done_eff;
   logic                       store_wr;
   logic                       emit_frame;

   assign req_ready    = !frm_valid_ff || frm_ready;
   assign req_ch.ready = req_ready;
   assign req_fire     = req_ch.valid && req_ready;

   // start flag restarts position and CRC before the byte is used
   assign pos_eff  = req_ch.frame_start ? '0 : byte_position_ff;
   assign crc_eff  = req_ch.frame_start ? htfd_pkg::CRC_INIT : crc_ff;
   assign done_eff = req_ch.frame_start ? 1'b0 : frame_done_ff;

   assign emit_frame = !done_eff &&
                       (pos_eff == htfd_pkg::POS_W'(htfd_pkg::DATA_BYTES));

   always_comb begin
      byte_position_in = byte_position_ff;
      crc_in           = crc_ff;
      frame_done_in    = frame_done_ff;
      frm_valid_in     = frm_valid_ff && !frm_ready;
      frm_in           = frm_ff;
      store_wr         = 1'b0;
      if (req_fire) begin
         byte_position_in = pos_eff;
         crc_in           = crc_eff;
         frame_done_in    = done_eff;
         if (!done_eff) begin
            if (pos_eff < htfd_pkg::POS_W'(htfd_pkg::DATA_BYTES)) begin
               store_wr         = 1'b1;
               crc_in           = htfd_pkg::crc8_update(crc_eff, req_ch.rx_byte);
               byte_position_in = pos_eff + 1'b1;
            end else begin
               // CRC byte closes the frame
               frm_valid_in            = 1'b1;
               frm_in.status_byte      = store_ff[0];
               frm_in.humidity_code    = {store_ff[1], store_ff[2], store_ff[3][7:4]};
               frm_in.temperature_code = {store_ff[3][3:0], store_ff[4], store_ff[5]};
               frm_in.crc_ok           = (crc_eff == req_ch.rx_byte);
               frame_done_in           = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         crc_ff           <= htfd_pkg::CRC_INIT;
         frame_done_ff    <= 1'b1;
         frm_valid_ff     <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         crc_ff           <= crc_in;
         frame_done_ff    <= frame_done_in;
         frm_valid_ff     <= frm_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frm_ff <= frm_in;
      if (store_wr) begin
         store_ff[pos_eff] <= req_ch.rx_byte;
      end
   end

   assign frm_valid = frm_valid_ff;
   assign frm       = frm_ff;

   `HTFD_ASSERT_RST(a_pos_range, clock, reset, byte_position_ff <= htfd_pkg::POS_W'(htfd_pkg::DATA_BYTES))
   `HTFD_ASSERT_RST(a_emit_closes, clock, reset, (req_fire && emit_frame) |=> (frame_done_ff && frm_valid_ff))
   `HTFD_ASSERT_RST(a_start_crc, clock, reset, (req_fire && req_ch.frame_start) |=> (crc_ff == htfd_pkg::crc8_update(htfd_pkg::CRC_INIT, $past(req_ch.rx_byte))))

endmodule

`default_nettype wire

// ===== sv/humidity_temp_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top
// Decodes 7-byte humidity/temperature sensor replies into measurements.
//
// req_ch: one received byte per request; frame_start marks byte 0 of a
//   frame and drops any open frame. Bytes before a start or after the
//   CRC byte are taken and ignored.
// rsp_ch: one response per frame, issued for the CRC byte (byte 6), with
//   status, both 20-bit raw codes, crc_ok and converted values. A bad CRC
//   still yields a response with crc_ok low.
// Throughput: one request per cycle while req_ch.ready is high, set by the
//   byte-wide CRC update feeding the frame register.
// Path: the accepted CRC byte loads the frame register, and from there the
//   multiply goes straight into the response register.
// Reset: synchronous; waits for a start flag, no response pending.
// Stall: a held response keeps the frame register full; req_ch.ready drops
//   only when both are full, so nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_temp_frame_decoder_top_defines.svh"

module humidity_temp_frame_decoder_top (
   input  wire logic clock,
   input  wire logic reset,
   htfd_req_if.sink  req_ch,
   htfd_rsp_if.source rsp_ch
);

   localparam int unsigned T_PROD_W = htfd_pkg::RAW_W + htfd_pkg::TEMP_W;
   localparam int unsigned H_PROD_W = htfd_pkg::RAW_W + htfd_pkg::HUM_W;

   logic                frm_valid;
   logic                frm_ready;
   htfd_pkg::frame_type frm;

   htfd_collect u_collect (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .frm_valid (frm_valid),
      .frm_ready (frm_ready),
      .frm       (frm)
   );

   // ---- conversion: one multiply each, straight into the response register
   logic [T_PROD_W-1:0]          t_prod;
   logic [H_PROD_W-1:0]          h_prod;
   logic [htfd_pkg::TEMP_W-1:0]  temp_floor;
   logic [htfd_pkg::HUM_W-1:0]   hum_floor;

   assign t_prod = {{htfd_pkg::TEMP_W{1'b0}}, frm.temperature_code} *
                   {{htfd_pkg::RAW_W{1'b0}}, htfd_pkg::TEMP_SCALE};
   assign h_prod = {{htfd_pkg::HUM_W{1'b0}}, frm.humidity_code} *
                   {{htfd_pkg::RAW_W{1'b0}}, htfd_pkg::HUM_SCALE};

   // >> 20 of the product; floor is the truncation
   assign temp_floor = t_prod[T_PROD_W-1 -: htfd_pkg::TEMP_W];
   assign hum_floor  = h_prod[H_PROD_W-1 -: htfd_pkg::HUM_W];

   // ---- response register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               load;
   logic [7:0]                         status_ff;
   logic [htfd_pkg::RAW_W-1:0]         raw_h_ff;
   logic [htfd_pkg::RAW_W-1:0]         raw_t_ff;
   logic                               crc_ok_ff;
   logic                               hum_valid_ff;
   logic [htfd_pkg::TEMP_W-1:0]        temp_ff;
   logic [htfd_pkg::HUM_W-1:0]         hum_ff;

   assign frm_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign load         = frm_valid && frm_ready;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff    <= frm.status_byte;
         raw_h_ff     <= frm.humidity_code;
         raw_t_ff     <= frm.temperature_code;
         crc_ok_ff    <= frm.crc_ok;
         hum_valid_ff <= (frm.humidity_code != '0);
         temp_ff      <= temp_floor - htfd_pkg::TEMP_OFFSET;  // wraps to two's complement
         hum_ff       <= hum_floor;                           // zero raw gives zero
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.status_byte       = status_ff;
   assign rsp_ch.humidity_code     = raw_h_ff;
   assign rsp_ch.temperature_code  = raw_t_ff;
   assign rsp_ch.crc_ok            = crc_ok_ff;
   assign rsp_ch.humidity_valid    = hum_valid_ff;
   assign rsp_ch.temperature_centi = $signed(temp_ff);
   assign rsp_ch.humidity_centi    = hum_ff;

   `HTFD_ASSERT_RST(a_hum_zero, clock, reset, (rsp_ch.valid && !rsp_ch.humidity_valid) |-> (rsp_ch.humidity_centi == '0))
   `HTFD_ASSERT_RST(a_temp_range, clock, reset, rsp_ch.valid |-> ((rsp_ch.temperature_centi >= -15'sd5000) && (rsp_ch.temperature_centi <= 15'sd14999)))
   `HTFD_ASSERT_RST(a_frame_held, clock, reset, (frm_valid && !frm_ready) |=> frm_valid)
   `HTFD_ASSERT(a_reset_clears, clock, reset |=> !rsp_ch.valid)

endmodule

`default_nettype wire

// ===== tb/humidity_temp_frame_decoder_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top_test
// Streams sensor reply bytes into the frame decoder with bursty traffic and a
// stalling receiver, decodes every accepted byte in a local frame tracker and
// checks each measurement, field by field, against the oldest pending one.
// ----------------------------------------------------------------------------

module humidity_temp_frame_decoder_top_test;

   // conversion constants: raw codes are fractions of 2^20
   localparam int unsigned TEMP_SPAN_CENTI = 20000;
   localparam int          TEMP_BASE_CENTI = 5000;
   localparam int unsigned HUM_SPAN_CENTI  = 10000;
   localparam int unsigned RAW_FRAC_BITS   = 20;

   localparam int NUM_RANDOM_BYTES = 1300;
   localparam int HOLD_OFF_CYCLES  = 300;   // long receiver stall
   localparam int HOLD_OFF_AFTER   = 25;    // measurements seen before it
   localparam int DRAIN_CYCLES     = 8;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } rx_item_type;

   typedef struct packed {
      logic [7:0]                         status_byte;
      logic [htfd_pkg::RAW_W-1:0]         humidity_code;
      logic [htfd_pkg::RAW_W-1:0]         temperature_code;
      logic                               crc_ok;
      logic                               humidity_valid;
      logic signed [htfd_pkg::TEMP_W-1:0] temperature_centi;
      logic [htfd_pkg::HUM_W-1:0]         humidity_centi;
   } measurement_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side drive, applied on the falling edge
   logic       req_valid = 1'b0;
   logic [7:0] req_byte  = 8'h00;
   logic       req_start = 1'b0;
   logic       req_taken = 1'b0;   // request accepted at the last rising edge

   // response side drive
   logic rsp_ready = 1'b0;
   logic hold_off  = 1'b0;

   htfd_req_if req_ch ();
   htfd_rsp_if rsp_ch ();

   assign req_ch.valid       = req_valid;
   assign req_ch.rx_byte     = req_byte;
   assign req_ch.frame_start = req_start;
   assign rsp_ch.ready       = rsp_ready;

   humidity_temp_frame_decoder_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rx_item_type     byte_queue[$];          // bytes still to be sent
   measurement_type measurement_queue[$];   // decoded frames awaiting response
   rx_item_type     next_item;

   int mismatch_count = 0;
   int rsp_count      = 0;

   // local frame tracker
   logic [2:0] rx_position = '0;
   logic [7:0] rx_crc      = htfd_pkg::CRC_INIT;
   logic [7:0] rx_store [0:htfd_pkg::DATA_BYTES-1];
   logic       rx_idle     = 1'b1;   // no frame open until a start flag

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // CRC-8, MSB first, no final xor
   // ------------------------------------------------------------------------
   function automatic logic [7:0] crc8_step(input logic [7:0] acc,
                                            input logic [7:0] data_in);
      logic [7:0] r;
      logic       msb;
      r = acc ^ data_in;
      repeat (8) begin
         msb = r[7];
         r   = r << 1;
         if (msb) begin
            r = r ^ htfd_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Frame tracker: consumes one accepted byte, queues a measurement on the
   // CRC byte of an open frame.
   // ------------------------------------------------------------------------
   task automatic decode_rx_byte(input logic [7:0] b, input logic start);
      measurement_type            m;
      logic [htfd_pkg::RAW_W-1:0] rh;
      logic [htfd_pkg::RAW_W-1:0] rt;
      logic [63:0]                scaled;
      int                         centi;
      if (start) begin
         rx_position = '0;
         rx_crc      = htfd_pkg::CRC_INIT;
         rx_idle     = 1'b0;
      end
      if (rx_idle) begin
         return;   // before any start or after a completed frame
      end
      if (rx_position < htfd_pkg::DATA_BYTES) begin
         rx_store[rx_position] = b;
         rx_crc      = crc8_step(rx_crc, b);
         rx_position = rx_position + 3'd1;
         return;
      end
      // CRC byte closes the frame
      rh = {rx_store[1], rx_store[2], rx_store[3][7:4]};
      rt = {rx_store[3][3:0], rx_store[4], rx_store[5]};
      m.status_byte      = rx_store[0];
      m.humidity_code    = rh;
      m.temperature_code = rt;
      m.crc_ok           = (rx_crc == b);
      m.humidity_valid   = (rh != '0);
      scaled  = (64'(rt) * 64'(TEMP_SPAN_CENTI)) >> RAW_FRAC_BITS;
      centi   = int'(scaled) - TEMP_BASE_CENTI;
      m.temperature_centi = centi[htfd_pkg::TEMP_W-1:0];
      scaled  = (64'(rh) * 64'(HUM_SPAN_CENTI)) >> RAW_FRAC_BITS;
      m.humidity_centi = (rh == '0) ? '0 : scaled[htfd_pkg::HUM_W-1:0];
      measurement_queue.push_back(m);
      rx_idle = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Mismatch reporting
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("response %0d %s: got 0x%0h, expected 0x%0h",
                                   rsp_count, name, got, want));
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input logic start);
      rx_item_type it;
      it.rx_byte     = b;
      it.frame_start = start;
      byte_queue.push_back(it);
   endtask

   // bytes 0..5 packed with byte 0 in the top; CRC good or deliberately wrong
   task automatic push_frame(input logic [47:0] data, input bit crc_good);
      logic [7:0] crc;
      logic [7:0] b;
      crc = htfd_pkg::CRC_INIT;
      for (int i = 0; i < htfd_pkg::DATA_BYTES; i++) begin
         b   = data[47 - 8*i -: 8];
         crc = crc8_step(crc, b);
         push_byte(b, i == 0);
      end
      if (!crc_good) begin
         crc = crc ^ 8'($urandom_range(1, 255));
      end
      push_byte(crc, 1'b0);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------------
   initial begin
      logic [47:0] data;
      int          kind;
      int          n;

      // directed: bytes before any start are dropped
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      // all-zero frame: zero humidity flagged, coldest temperature, good CRC
      push_frame(48'h0, 1'b1);
      // trailing byte after the CRC byte is ignored
      push_byte(8'h5A, 1'b0);
      // start in mid-frame drops the open frame
      push_byte(8'h12, 1'b1);
      push_byte(8'h34, 1'b0);
      // all-ones frame: largest raw codes, bad CRC still yields a response
      push_frame({48{1'b1}}, 1'b0);

      // random: mostly well-formed frames with random content
      while (byte_queue.size() < NUM_RANDOM_BYTES) begin
         kind = $urandom_range(0, 99);
         data = {$urandom, 16'($urandom)};
         if ($urandom_range(0, 9) == 0) begin
            data[39:20] = '0;                    // zero raw humidity
         end
         if ($urandom_range(0, 15) == 0) begin
            data[19:0] = {20{$urandom_range(0, 1) == 1}};   // temperature extreme
         end
         if (kind < 80) begin
            push_frame(data, $urandom_range(0, 4) != 0);
         end else if (kind < 88) begin
            // truncated frame, cut off by the next start
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               push_byte(data[47 - 8*i -: 8], i == 0);
            end
         end else if (kind < 94) begin
            n = $urandom_range(1, 4);           // junk after a frame
            for (int i = 0; i < n; i++) begin
               push_byte(8'($urandom), 1'b0);
            end
         end else begin
            n = $urandom_range(1, 5);           // noise with random starts
            for (int i = 0; i < n; i++) begin
               push_byte(8'($urandom), 1'($urandom_range(0, 1)));
            end
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all requests accepted, then all measurements returned
      while (byte_queue.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (measurement_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // hard stop
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps. A
   // request stays up until it is taken.
   // ------------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            next_item = byte_queue.pop_front();
            req_valid <= 1'b1;
            req_byte  <= next_item.rx_byte;
            req_start <= next_item.frame_start;
            if (burst_left <= 1) begin
               // now and then a long back-to-back stretch
               burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response receiver: mode switches between always ready, a rotating mask
   // and coin flips; the hold-off process overrides it.
   // ------------------------------------------------------------------------
   int          mode_left   = 0;
   int          stall_mode  = 0;
   logic [31:0] stall_mask  = '1;
   logic [4:0]  stall_phase = '0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 5'd1;
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_mask <= $urandom;
            mode_left  <= $urandom_range(32, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= stall_mask[stall_phase];
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // long stall so that the decoder fills and pushes back on requests
   initial begin
      @(negedge clock);
      while (reset || rsp_count < HOLD_OFF_AFTER) begin
         @(posedge clock);
      end
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Monitor: track accepted requests, check accepted responses
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ch.ready;
         if (req_valid && req_ch.ready) begin
            decode_rx_byte(req_byte, req_start);
         end
         if (rsp_ch.valid && rsp_ready) begin
            if (measurement_queue.size() == 0) begin
               report_mismatch($sformatf("response %0d with no frame pending",
                                         rsp_count));
            end else begin
               check_field("status_byte", 32'(rsp_ch.status_byte),
                           32'(measurement_queue[0].status_byte));
               check_field("humidity_code", 32'(rsp_ch.humidity_code),
                           32'(measurement_queue[0].humidity_code));
               check_field("temperature_code", 32'(rsp_ch.temperature_code),
                           32'(measurement_queue[0].temperature_code));
               check_field("crc_ok", 32'(rsp_ch.crc_ok),
                           32'(measurement_queue[0].crc_ok));
               check_field("humidity_valid", 32'(rsp_ch.humidity_valid),
                           32'(measurement_queue[0].humidity_valid));
               // compared as raw bits, no sign extension
               check_field("temperature_centi",
                           {17'd0, rsp_ch.temperature_centi},
                           {17'd0, measurement_queue[0].temperature_centi});
               check_field("humidity_centi", 32'(rsp_ch.humidity_centi),
                           32'(measurement_queue[0].humidity_centi));
               void'(measurement_queue.pop_front());
            end
            rsp_count <= rsp_count + 1;
         end
      end
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/htfd_pkg.sv
sv/htfd_if.sv
sv/htfd_collect.sv
sv/humidity_temp_frame_decoder_top.sv
tb/humidity_temp_frame_decoder_top_test.sv
